/* hdl/tdss_pkg.sv */
// Shared types, constants and helpers of the timed state sequencer.
package tdss_pkg;

    localparam int NUM_STATES  = 16;
    localparam int STATE_W     = 5;
    localparam int HITS_W      = 16;
    localparam int ROW_IDX_W   = 4;
    localparam int TIME_W      = 32;
    localparam int INTERVAL_W  = 31;
    localparam int CFG_DATA_W  = 31;
    localparam int CFG_IDX_W   = 2;
    localparam int TIMED_ROWS_DEF     = 16;
    localparam int PREDICATE_ROWS_DEF = 16;

    // state code that means halted, or no state
    localparam logic [STATE_W-1:0] HALT = STATE_W'(NUM_STATES);

    typedef enum logic [1:0] {
        KIND_UPDATE = 2'd0,
        KIND_TIMED  = 2'd1,
        KIND_PRED   = 2'd2,
        KIND_RSVD   = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERVAL  = 2'd0,
        CFG_INIT      = 2'd1,
        CFG_TIMED_CNT = 2'd2,
        CFG_PRED_CNT  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_kind                  kind;
        logic [TIME_W-1:0]      now;
        logic [HITS_W-1:0]      predicate_hits;
        logic [ROW_IDX_W-1:0]   row_index;
        logic [STATE_W-1:0]     row_from;
        logic [STATE_W-1:0]     row_to;
        logic [TIME_W-1:0]      row_duration;
    } t_tdss_in;

    typedef struct packed {
        logic                   ran;
        logic [STATE_W-1:0]     executed_state;
        logic                   predicate_fired;
        logic                   timed_fired;
        logic [STATE_W-1:0]     final_state;
    } t_tdss_out;

    typedef struct packed {
        logic [STATE_W-1:0]     from;
        logic [STATE_W-1:0]     to;
        logic [TIME_W-1:0]      duration;
    } t_trow;

    typedef struct packed {
        logic [STATE_W-1:0]     from;
        logic [STATE_W-1:0]     to;
    } t_prow;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_PSCAN,
        S_TSETUP,
        S_TSCAN,
        S_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic check;
        logic pscan;
        logic tsetup;
        logic tscan;
        logic load_out;
    } t_tdss_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_is_update;
        logic due_ok;
        logic p_empty;
        logic p_stop;
        logic halted;
        logic t_empty;
        logic t_stop;
    } t_tdss_sts;

    // any code at or above the state count means halted
    function automatic logic [STATE_W-1:0] norm_state(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] r;
        r = (s >= HALT) ? HALT : s;
        return r;
    endfunction

endpackage

/* hdl/tdss_ctrl.sv */
// Controller state machine of the timed state sequencer.
module tdss_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  tdss_pkg::t_tdss_sts   i_sts,
    output tdss_pkg::t_tdss_cmd   o_cmd
);

    tdss_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdss_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tdss_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.in_is_update ? tdss_pkg::S_CHECK : tdss_pkg::S_FINISH;
                end
            end
            tdss_pkg::S_CHECK: begin
                if (!i_sts.due_ok) begin
                    n_state = tdss_pkg::S_FINISH;
                end else if (i_sts.p_empty) begin
                    n_state = tdss_pkg::S_TSETUP;
                end else begin
                    n_state = tdss_pkg::S_PSCAN;
                end
            end
            tdss_pkg::S_PSCAN: begin
                if (i_sts.p_stop) begin
                    n_state = tdss_pkg::S_TSETUP;
                end
            end
            tdss_pkg::S_TSETUP: begin
                n_state = (i_sts.halted || i_sts.t_empty) ? tdss_pkg::S_FINISH
                                                          : tdss_pkg::S_TSCAN;
            end
            tdss_pkg::S_TSCAN: begin
                if (i_sts.t_stop) begin
                    n_state = tdss_pkg::S_FINISH;
                end
            end
            tdss_pkg::S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = tdss_pkg::S_IDLE;
                end
            end
            default: n_state = tdss_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = (r_state == tdss_pkg::S_IDLE) && i_in_valid;
        o_cmd.check    = (r_state == tdss_pkg::S_CHECK);
        o_cmd.pscan    = (r_state == tdss_pkg::S_PSCAN);
        o_cmd.tsetup   = (r_state == tdss_pkg::S_TSETUP);
        o_cmd.tscan    = (r_state == tdss_pkg::S_TSCAN);
        o_cmd.load_out = (r_state == tdss_pkg::S_FINISH) && (!r_out_valid || !i_out_stall);
        n_out_valid    = o_cmd.load_out || (r_out_valid && i_out_stall);
    end

    assign o_in_stall  = (r_state != tdss_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* hdl/tdss_dp.sv */
// Datapath of the timed state sequencer: registers, row tables and scan logic.
module tdss_dp #(
    parameter int TIMED_ROWS     = tdss_pkg::TIMED_ROWS_DEF,
    parameter int PREDICATE_ROWS = tdss_pkg::PREDICATE_ROWS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tdss_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tdss_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  tdss_pkg::t_tdss_in                   i_in_data,
    input  tdss_pkg::t_tdss_cmd                  i_cmd,
    output tdss_pkg::t_tdss_sts                  o_sts,
    output tdss_pkg::t_tdss_out                  o_out_data
);

    localparam int TCNT_W = $clog2(TIMED_ROWS + 1);
    localparam int PCNT_W = $clog2(PREDICATE_ROWS + 1);
    localparam int TIDX_W = (TIMED_ROWS > 1) ? $clog2(TIMED_ROWS) : 1;
    localparam int PIDX_W = (PREDICATE_ROWS > 1) ? $clog2(PREDICATE_ROWS) : 1;
    localparam int SW     = tdss_pkg::STATE_W;
    localparam int TW     = tdss_pkg::TIME_W;

    // configuration
    logic [tdss_pkg::INTERVAL_W-1:0] r_interval;
    logic [SW-1:0]                   r_timed_used;
    logic [SW-1:0]                   r_pred_used;

    // sequencer state
    logic [SW-1:0] r_present;
    logic [TW-1:0] r_entry;
    logic [TW-1:0] r_last;

    // item being worked on
    logic [TW-1:0]               r_now;
    logic [tdss_pkg::HITS_W-1:0] r_hits;
    logic [TW-1:0]               r_dwell;

    // result flags
    logic          r_ran;
    logic [SW-1:0] r_exec;
    logic          r_pf;
    logic          r_tf;
    tdss_pkg::t_tdss_out r_out;

    // row tables
    tdss_pkg::t_trow r_tmem [TIMED_ROWS];
    tdss_pkg::t_prow r_pmem [PREDICATE_ROWS];
    tdss_pkg::t_trow r_tq;
    tdss_pkg::t_prow r_pq;
    logic [TCNT_W-1:0] r_tidx;
    logic [PCNT_W-1:0] r_pidx;

    logic [TIDX_W+3:0] t_wr_ext;
    logic [PIDX_W+3:0] p_wr_ext;
    logic              t_wr_en, p_wr_en;
    logic [TCNT_W-1:0] t_next, t_lim;
    logic [PCNT_W-1:0] p_next, p_lim;
    logic [TIDX_W-1:0] t_rd_addr;
    logic [PIDX_W-1:0] p_rd_addr;
    logic [PCNT_W+3:0] p_hit_idx;
    logic              p_hit, p_match, t_match;
    logic [TW-1:0]     due;

    always_comb begin
        t_wr_ext  = (TIDX_W + 4)'(i_in_data.row_index);
        p_wr_ext  = (PIDX_W + 4)'(i_in_data.row_index);
        t_wr_en   = i_cmd.accept && (i_in_data.kind == tdss_pkg::KIND_TIMED)
                    && (t_wr_ext < (TIDX_W + 4)'(TIMED_ROWS));
        p_wr_en   = i_cmd.accept && (i_in_data.kind == tdss_pkg::KIND_PRED)
                    && (p_wr_ext < (PIDX_W + 4)'(PREDICATE_ROWS));

        // scan limits saturate at the table size
        t_lim = (8'(r_timed_used) > 8'(TIMED_ROWS)) ? TCNT_W'(TIMED_ROWS)
                                                    : TCNT_W'(r_timed_used);
        p_lim = (8'(r_pred_used) > 8'(PREDICATE_ROWS)) ? PCNT_W'(PREDICATE_ROWS)
                                                       : PCNT_W'(r_pred_used);
        t_next    = r_tidx + TCNT_W'(1);
        p_next    = r_pidx + PCNT_W'(1);
        t_rd_addr = i_cmd.tsetup ? '0 : t_next[TIDX_W-1:0];
        p_rd_addr = i_cmd.check  ? '0 : p_next[PIDX_W-1:0];

        // rows past the outcome bits never hit
        p_hit_idx = (PCNT_W + 4)'(r_pidx);
        p_hit     = (p_hit_idx < (PCNT_W + 4)'(tdss_pkg::HITS_W)) && r_hits[p_hit_idx[3:0]];
        p_match   = (r_pq.from == r_present) && p_hit;
        t_match   = (r_tq.from == r_present) && (r_tq.duration <= r_dwell);

        due = r_last + TW'(r_interval);

        o_sts.in_is_update = (i_in_data.kind == tdss_pkg::KIND_UPDATE);
        o_sts.due_ok       = (r_present < tdss_pkg::HALT) && (r_now >= due);
        o_sts.p_empty      = (p_lim == '0);
        o_sts.p_stop       = p_match || (p_next >= p_lim);
        o_sts.halted       = (r_present >= tdss_pkg::HALT);
        o_sts.t_empty      = (t_lim == '0);
        o_sts.t_stop       = t_match || (t_next >= t_lim);
    end

    // table write port and registered read port
    always_ff @(posedge i_clk) begin
        if (t_wr_en) begin
            r_tmem[t_wr_ext[TIDX_W-1:0]] <= '{from:     i_in_data.row_from,
                                              to:       tdss_pkg::norm_state(i_in_data.row_to),
                                              duration: i_in_data.row_duration};
        end
        if (p_wr_en) begin
            r_pmem[p_wr_ext[PIDX_W-1:0]] <= '{from: i_in_data.row_from,
                                              to:   tdss_pkg::norm_state(i_in_data.row_to)};
        end
        r_tq <= r_tmem[t_rd_addr];
        r_pq <= r_pmem[p_rd_addr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_now  <= i_in_data.now;
            r_hits <= i_in_data.predicate_hits;
        end
        if (i_cmd.tsetup) begin
            r_dwell <= r_now - r_entry;
        end
        if (i_cmd.load_out) begin
            r_out <= '{ran:             r_ran,
                       executed_state:  r_exec,
                       predicate_fired: r_pf,
                       timed_fired:     r_tf,
                       final_state:     r_present};
        end
    end

    // sequencer state, configuration and scan counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval   <= '0;
            r_timed_used <= '0;
            r_pred_used  <= '0;
            r_present    <= tdss_pkg::norm_state('0);
            r_entry      <= '0;
            r_last       <= '0;
            r_ran        <= 1'b0;
            r_exec       <= tdss_pkg::HALT;
            r_pf         <= 1'b0;
            r_tf         <= 1'b0;
            r_tidx       <= '0;
            r_pidx       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (tdss_pkg::t_cfg_idx'(i_cfg_idx))
                    tdss_pkg::CFG_INTERVAL:  r_interval <= i_cfg_data[tdss_pkg::INTERVAL_W-1:0];
                    tdss_pkg::CFG_INIT: begin
                        r_present <= tdss_pkg::norm_state(i_cfg_data[SW-1:0]);
                        r_entry   <= '0;
                    end
                    tdss_pkg::CFG_TIMED_CNT: r_timed_used <= i_cfg_data[SW-1:0];
                    tdss_pkg::CFG_PRED_CNT:  r_pred_used  <= i_cfg_data[SW-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_ran  <= 1'b0;
                r_exec <= tdss_pkg::HALT;
                r_pf   <= 1'b0;
                r_tf   <= 1'b0;
            end
            if (i_cmd.check) begin
                r_pidx <= '0;
                if (o_sts.due_ok) begin
                    r_last <= r_now;
                    r_ran  <= 1'b1;
                    r_exec <= r_present;
                end
            end
            if (i_cmd.pscan) begin
                r_pidx <= p_next;
                if (p_match) begin
                    r_present <= r_pq.to;
                    r_entry   <= r_now;
                    r_pf      <= 1'b1;
                end
            end
            if (i_cmd.tsetup) begin
                r_tidx <= '0;
            end
            if (i_cmd.tscan) begin
                r_tidx <= t_next;
                if (t_match) begin
                    r_present <= r_tq.to;
                    r_entry   <= r_now;
                    r_tf      <= 1'b1;
                end
            end
        end
    end

    assign o_out_data = r_out;

endmodule

/* hdl/table_driven_timed_state_sequencer.sv */
// Top level of the table-driven timed state sequencer.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one beat per item:
// kind 1 and kind 2 beats load a row of the timed or the predicate table, a
// kind 0 beat is an update tick carrying the time and the predicate outcomes.
// Every input beat yields exactly one output beat (o_out_valid / i_out_stall /
// o_out_data) with the run flags and the state left behind.
// A row write or reserved beat goes from acceptance straight to the finish step;
// an update first passes the due check, and an ignored one then finishes; a
// running one scans P predicate rows, sets up the timed scan and scans T timed
// rows, P and T being the rows visited (up to the used-row counts). One row per
// cycle is read from each table during its scan. One item is worked
// at a time; o_in_stall is high from acceptance until the result is loaded,
// and the next beat can be taken in the cycle after the load.
// The output register parts the two sides: a new beat is accepted while the
// last result still waits; if the receiver stalls, hold the result and stall
// the following item at its final step until the register frees up.
// Reset (i_rst_n low, synchronous) clears configuration to zero, enters state 0
// and zeroes both timestamps. Table rows are undefined until written.
// Configuration writes (i_cfg_we) must only be issued while the block is idle.
module table_driven_timed_state_sequencer #(
    parameter int TIMED_ROWS     = tdss_pkg::TIMED_ROWS_DEF,
    parameter int PREDICATE_ROWS = tdss_pkg::PREDICATE_ROWS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tdss_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tdss_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  tdss_pkg::t_tdss_in               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output tdss_pkg::t_tdss_out              o_out_data
);

    tdss_pkg::t_tdss_cmd cmd;
    tdss_pkg::t_tdss_sts sts;

    // sequencing: accept, due check, predicate scan, timed scan, finish
    tdss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // tables, timestamps, present state and the output register
    tdss_dp #(
        .TIMED_ROWS     (TIMED_ROWS),
        .PREDICATE_ROWS (PREDICATE_ROWS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

    // one item at a time: stall straight after an accepted beat
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted beat");

    // an item that did not run reports no state and no transition
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.ran) |->
            (!o_out_data.predicate_fired && !o_out_data.timed_fired
             && o_out_data.executed_state == tdss_pkg::HALT))
        else $error("result flags set on an item that did not run");

    // a loaded result is offered in the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_out_valid)
        else $error("loaded result not offered");

    // the input stays stalled until the result is loaded
    a_release_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(o_in_stall) && !o_in_stall) |-> $past(cmd.load_out))
        else $error("input released without a result");

endmodule

/* bench/sequencer_checker.sv */
// Checker for the timed state sequencer: predicts every result beat and compares it.
module sequencer_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tdss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tdss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  tdss_pkg::t_tdss_in              i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  tdss_pkg::t_tdss_out             i_out_data,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int TABLE_DEPTH = 16;
    localparam int INTERVAL_W  = tdss_pkg::INTERVAL_W;
    localparam int STATE_W     = tdss_pkg::STATE_W;
    localparam int TIME_W      = tdss_pkg::TIME_W;
    localparam logic [STATE_W-1:0] HALT = tdss_pkg::HALT;

    logic [INTERVAL_W-1:0]    min_gap;
    logic [STATE_W-1:0]       timed_scan_cnt;
    logic [STATE_W-1:0]       pred_scan_cnt;
    logic [STATE_W-1:0]       cur_state;
    logic [TIME_W-1:0]        entry_tick;
    logic [TIME_W-1:0]        last_run_tick;
    tdss_pkg::t_trow          timed_rows [TABLE_DEPTH];
    tdss_pkg::t_prow          pred_rows  [TABLE_DEPTH];
    tdss_pkg::t_tdss_out      awaited_results [$];
    int                       mismatches = 0;

    assign o_fail_count = mismatches;

    // fold any code at or above the state count onto the halt code
    function automatic logic [STATE_W-1:0] to_state_code(input logic [STATE_W-1:0] s);
        return (s >= HALT) ? HALT : s;
    endfunction

    function automatic int scan_len(input logic [STATE_W-1:0] used);
        return (int'(used) > TABLE_DEPTH) ? TABLE_DEPTH : int'(used);
    endfunction

    // advance the mirrored sequencer by one input beat and return its result
    function automatic tdss_pkg::t_tdss_out next_sequencer_result(
        input tdss_pkg::t_tdss_in b);
        tdss_pkg::t_tdss_out r;
        logic [TIME_W-1:0]   due;
        logic [TIME_W-1:0]   dwell;
        r.ran             = 1'b0;
        r.executed_state  = HALT;
        r.predicate_fired = 1'b0;
        r.timed_fired     = 1'b0;
        case (b.kind)
            tdss_pkg::KIND_TIMED: begin
                timed_rows[b.row_index].from     = b.row_from;
                timed_rows[b.row_index].to       = to_state_code(b.row_to);
                timed_rows[b.row_index].duration = b.row_duration;
            end
            tdss_pkg::KIND_PRED: begin
                pred_rows[b.row_index].from = b.row_from;
                pred_rows[b.row_index].to   = to_state_code(b.row_to);
            end
            tdss_pkg::KIND_UPDATE: begin
                due = last_run_tick + TIME_W'(min_gap);
                if (cur_state < HALT && b.now >= due) begin
                    last_run_tick    = b.now;
                    r.ran            = 1'b1;
                    r.executed_state = cur_state;
                    for (int i = 0; i < scan_len(pred_scan_cnt); i++) begin
                        if (!r.predicate_fired && pred_rows[i].from == cur_state &&
                            b.predicate_hits[i]) begin
                            cur_state         = pred_rows[i].to;
                            entry_tick        = b.now;
                            r.predicate_fired = 1'b1;
                        end
                    end
                    // a halt from the predicate table skips the timed scan
                    if (cur_state < HALT) begin
                        dwell = b.now - entry_tick;
                        for (int i = 0; i < scan_len(timed_scan_cnt); i++) begin
                            if (!r.timed_fired && timed_rows[i].from == cur_state &&
                                timed_rows[i].duration <= dwell) begin
                                cur_state     = timed_rows[i].to;
                                entry_tick    = b.now;
                                r.timed_fired = 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        r.final_state = cur_state;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        tdss_pkg::t_tdss_out want;
        if (!i_rst_n) begin
            min_gap        = '0;
            timed_scan_cnt = '0;
            pred_scan_cnt  = '0;
            cur_state      = '0;
            entry_tick     = '0;
            last_run_tick  = '0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                timed_rows[i] = '0;
                pred_rows[i]  = '0;
            end
            awaited_results.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (tdss_pkg::t_cfg_idx'(i_cfg_idx))
                    tdss_pkg::CFG_INTERVAL:  min_gap = i_cfg_data[INTERVAL_W-1:0];
                    tdss_pkg::CFG_INIT: begin
                        cur_state  = to_state_code(i_cfg_data[STATE_W-1:0]);
                        entry_tick = '0;
                    end
                    tdss_pkg::CFG_TIMED_CNT: timed_scan_cnt = i_cfg_data[STATE_W-1:0];
                    tdss_pkg::CFG_PRED_CNT:  pred_scan_cnt  = i_cfg_data[STATE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                awaited_results.push_back(next_sequencer_result(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result beat with no result awaited");
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("ran", 32'(want.ran), 32'(i_out_data.ran));
                    check_field("executed_state", 32'(want.executed_state),
                                32'(i_out_data.executed_state));
                    check_field("predicate_fired", 32'(want.predicate_fired),
                                32'(i_out_data.predicate_fired));
                    check_field("timed_fired", 32'(want.timed_fired),
                                32'(i_out_data.timed_fired));
                    check_field("final_state", 32'(want.final_state),
                                32'(i_out_data.final_state));
                end
            end
            o_pending <= awaited_results.size();
        end
    end

endmodule

/* bench/tb_table_driven_timed_state_sequencer.sv */
// Testbench top: drives directed and random beats into the sequencer and gives the verdict.
module tb_table_driven_timed_state_sequencer;

    localparam int ITEM_TARGET   = 1150;
    localparam int IDLE_PCT      = 37;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int CALM_PHASE    = 6;
    localparam int HOLD_PHASE    = 8;

    localparam int STATE_W    = tdss_pkg::STATE_W;
    localparam int TIME_W     = tdss_pkg::TIME_W;
    localparam int HITS_W     = tdss_pkg::HITS_W;
    localparam int ROW_IDX_W  = tdss_pkg::ROW_IDX_W;
    localparam int INTERVAL_W = tdss_pkg::INTERVAL_W;
    localparam int CFG_IDX_W  = tdss_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = tdss_pkg::CFG_DATA_W;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = tdss_pkg::CFG_INTERVAL;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    tdss_pkg::t_tdss_in    in_data  = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    tdss_pkg::t_tdss_out   out_data;

    int                    fail_count;
    int                    pending;

    // receiver control: calm switches idling off, a hold request buys a long stall
    bit                    calm        = 1'b0;
    int                    hold_asked  = 0;
    int                    hold_served = 0;
    int                    hold_left   = 0;
    int                    quiet       = 0;

    int                    items_sent   = 0;
    logic [TIME_W-1:0]     tick         = '0;
    logic [INTERVAL_W-1:0] interval_now = '0;

    table_driven_timed_state_sequencer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    sequencer_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    // Receiver: serve a pending hold request first, otherwise stall at random
    // unless the calm stretch is on. The hold is counted here, not by the sender.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_asked != hold_served) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            out_stall   <= 1'b1;
        end else begin
            out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog: count cycles in which neither channel moves a beat.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Update beat; fill the fields the block ignores with noise.
    function automatic tdss_pkg::t_tdss_in make_update(input logic [TIME_W-1:0] at,
                                                       input logic [HITS_W-1:0] hits);
        tdss_pkg::t_tdss_in b;
        b                = {$urandom, $urandom, $urandom};
        b.kind           = tdss_pkg::KIND_UPDATE;
        b.now            = at;
        b.predicate_hits = hits;
        return b;
    endfunction

    function automatic tdss_pkg::t_tdss_in make_row(input tdss_pkg::t_kind k,
                                                    input logic [ROW_IDX_W-1:0] idx,
                                                    input logic [STATE_W-1:0] from_s,
                                                    input logic [STATE_W-1:0] to_s,
                                                    input logic [TIME_W-1:0] dur);
        tdss_pkg::t_tdss_in b;
        b              = {$urandom, $urandom, $urandom};
        b.kind         = k;
        b.row_index    = idx;
        b.row_from     = from_s;
        b.row_to       = to_s;
        b.row_duration = dur;
        return b;
    endfunction

    // Random row: keep sources and targets mostly within a few states so that
    // rows match often; now and then reach the full code range, halt included.
    function automatic tdss_pkg::t_tdss_in random_row(input tdss_pkg::t_kind k,
                                                      input logic [ROW_IDX_W-1:0] idx);
        logic [STATE_W-1:0] from_s;
        logic [STATE_W-1:0] to_s;
        logic [TIME_W-1:0]  dur;
        int                 roll;
        roll   = $urandom_range(99);
        from_s = STATE_W'((roll < 85) ? $urandom_range(3) :
                          (roll < 93) ? $urandom_range(15) : $urandom_range(31, 16));
        roll   = $urandom_range(99);
        to_s   = STATE_W'((roll < 90) ? $urandom_range(3) :
                          (roll < 97) ? $urandom_range(15) : $urandom_range(31, 16));
        case ($urandom_range(19))
            0:       dur = '0;
            1:       dur = '1;
            2:       dur = $urandom;
            default: dur = $urandom_range(80);
        endcase
        return make_row(k, idx, from_s, to_s, dur);
    endfunction

    function automatic logic [HITS_W-1:0] pick_hits();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return HITS_W'(1) << $urandom_range(HITS_W - 1);
            default: return HITS_W'($urandom);
        endcase
    endfunction

    // Mostly in-order updates spaced at least one interval apart; the rest is
    // noise: updates at random times, stray row writes and reserved beats.
    function automatic tdss_pkg::t_tdss_in pick_beat();
        tdss_pkg::t_tdss_in b;
        int                 roll;
        roll = $urandom_range(99);
        if (roll < 85) begin
            tick = tick + TIME_W'(interval_now) + $urandom_range(40);
            b    = make_update(tick, pick_hits());
        end else if (roll < 89) begin
            b = make_update($urandom, pick_hits());
        end else if (roll < 95) begin
            b = random_row(($urandom_range(1) != 0) ? tdss_pkg::KIND_TIMED
                                                    : tdss_pkg::KIND_PRED,
                           ROW_IDX_W'($urandom_range(15)));
        end else begin
            b      = {$urandom, $urandom, $urandom};
            b.kind = tdss_pkg::KIND_RSVD;
        end
        return b;
    endfunction

    // Offer one beat, idling first at random, and hold it until it is taken.
    task automatic send_beat(input tdss_pkg::t_tdss_in b);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // Drop valid and wait until every awaited result has come back, then let
    // the block settle before anything touches the registers.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all four registers back to back; unused high data bits carry noise.
    task automatic load_settings(input logic [INTERVAL_W-1:0] gap,
                                 input logic [STATE_W-1:0] init,
                                 input logic [STATE_W-1:0] timed_cnt,
                                 input logic [STATE_W-1:0] pred_cnt);
        cfg_we   <= 1'b1;
        cfg_idx  <= tdss_pkg::CFG_INTERVAL;
        cfg_data <= gap;
        @(posedge clk);
        cfg_idx  <= tdss_pkg::CFG_INIT;
        cfg_data <= {(CFG_DATA_W - STATE_W)'($urandom), init};
        @(posedge clk);
        cfg_idx  <= tdss_pkg::CFG_TIMED_CNT;
        cfg_data <= {(CFG_DATA_W - STATE_W)'($urandom), timed_cnt};
        @(posedge clk);
        cfg_idx  <= tdss_pkg::CFG_PRED_CNT;
        cfg_data <= {(CFG_DATA_W - STATE_W)'($urandom), pred_cnt};
        @(posedge clk);
        cfg_we   <= 1'b0;
        interval_now = gap;
    endtask

    // Load every row of both tables, so no later scan can reach an unwritten row.
    task automatic program_tables();
        for (int r = 0; r < 16; r++) begin
            send_beat(random_row(tdss_pkg::KIND_TIMED, ROW_IDX_W'(r)));
            send_beat(random_row(tdss_pkg::KIND_PRED, ROW_IDX_W'(r)));
        end
    endtask

    initial begin
        logic [INTERVAL_W-1:0] gap;
        logic [STATE_W-1:0]    init;
        logic [STATE_W-1:0]    timed_cnt;
        logic [STATE_W-1:0]    pred_cnt;
        int                    phase;
        int                    burst;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, no rows scanned.
        send_beat(make_update('0, '0));
        send_beat('1);                                  // reserved kind, all ones
        send_beat(make_update('1, '1));

        // Two rows per table; the interval makes the next due time wrap to 4.
        drain_results();
        load_settings(31'd5, 5'd0, 5'd2, 5'd2);
        send_beat(make_row(tdss_pkg::KIND_TIMED, 4'd0, 5'd0, 5'd1, '1));
        send_beat(make_row(tdss_pkg::KIND_TIMED, 4'd1, 5'd1, 5'd2, '0));
        // source out of range: never matches
        send_beat(make_row(tdss_pkg::KIND_PRED, 4'd0, 5'd31, 5'd3, '0));
        // target out of range: halts
        send_beat(make_row(tdss_pkg::KIND_PRED, 4'd1, 5'd0, 5'd31, '0));
        send_beat(make_update(32'd3, '0));              // too early
        send_beat(make_update(32'd4, '0));              // runs, dwell too short for row 0
        send_beat(make_update(32'd9, 16'h0002));        // predicate halt, timed scan skipped
        send_beat(make_update(32'd20, '1));             // halted: ignored

        // Restart in state 1: a zero-duration timed row fires at once.
        drain_results();
        load_settings(31'd5, 5'd1, 5'd2, 5'd2);
        send_beat(make_update(32'd25, '0));
        send_beat(make_row(tdss_pkg::KIND_PRED, 4'd0, 5'd2, 5'd1, '0));
        send_beat(make_update(32'd30, 16'h0001));       // predicate then timed in one update
        send_beat(make_update(32'd35, '0));

        // Initial state codes that mean halted.
        drain_results();
        load_settings(31'd0, 5'd31, 5'd2, 5'd2);
        send_beat(make_update(32'd40, '1));
        drain_results();
        load_settings(31'd0, 5'd16, 5'd2, 5'd2);
        send_beat(make_update(32'd50, '1));

        // Random phases: extremes of the settings first, then random settings.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            drain_results();
            case (phase)
                0: begin
                    gap = '0;     init = 5'd0;  timed_cnt = 5'd16; pred_cnt = 5'd16;
                end
                1: begin
                    gap = '1;     init = 5'd3;  timed_cnt = 5'd31; pred_cnt = 5'd31;
                end
                2: begin
                    gap = 31'd1;  init = 5'd2;  timed_cnt = 5'd0;  pred_cnt = 5'd0;
                end
                3: begin
                    gap = '0;     init = 5'd31; timed_cnt = 5'd16; pred_cnt = 5'd16;
                end
                4: begin
                    gap = 31'd3;  init = 5'd15; timed_cnt = 5'd17; pred_cnt = 5'd1;
                end
                default: begin
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4, 5: gap = '0;
                        6, 7, 8:          gap = INTERVAL_W'($urandom_range(60, 1));
                        default:          gap = INTERVAL_W'($urandom);
                    endcase
                    init      = STATE_W'(($urandom_range(99) < 90) ? $urandom_range(3) :
                                                                     $urandom_range(31));
                    timed_cnt = STATE_W'(($urandom_range(9) < 8) ? $urandom_range(16) :
                                                                   $urandom_range(31, 17));
                    pred_cnt  = STATE_W'(($urandom_range(9) < 8) ? $urandom_range(16) :
                                                                   $urandom_range(31, 17));
                end
            endcase
            load_settings(gap, init, timed_cnt, pred_cnt);
            if (phase == 0 || $urandom_range(9) < 3)
                program_tables();
            calm  <= (phase == CALM_PHASE);
            burst  = (phase == CALM_PHASE) ? 150 : $urandom_range(70, 30);
            // keep offering beats while the receiver holds off, so the block backs up
            if (phase == HOLD_PHASE)
                hold_asked <= hold_asked + 1;
            repeat (burst) send_beat(pick_beat());
            phase++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
